>>> hw/rtl/ows_pkg.sv
// Shared types, codes and the CRC-8 step for the 1-Wire ROM search engine.
// No dependencies; imported by the engine and its testbench.
package ows_pkg;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_BITS  = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_READ = 2'd2;

    localparam logic [1:0] ACT_RESET  = 2'd0;
    localparam logic [1:0] ACT_CMD    = 2'd1;
    localparam logic [1:0] ACT_DIR    = 2'd2;
    localparam logic [1:0] ACT_FINISH = 2'd3;

    localparam logic [1:0] PRES_OK = 2'd0;

    localparam logic [7:0] SEARCH_CMD_RESET = 8'hF0;
    localparam logic [7:0] CRC_POLY         = 8'h8C;

    localparam logic [6:0] ROM_BITS_END   = 7'd65;
    localparam logic [6:0] FAMILY_BIT_END = 7'd9;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  out_byte;
        logic        direction;
        logic        found;
        logic [63:0] rom_id;
        logic        last_device;
        logic [6:0]  last_discrepancy;
        logic [3:0]  family_discrepancy;
        logic        last_of_run;
    } ows_result_t;

    // 1-Wire CRC-8 (x^8 + x^5 + x^4 + 1), reflected, one byte LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc_in;
        d = data;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[0] ^ d[0];
            c = c >> 1;
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/ows_cmd_if.sv
// Input channel of the ROM search engine: one bus event word per handshake.
// Standalone; fields follow the engine's input word.
interface ows_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       restart;
    logic [1:0] presence;
    logic       id_bit;
    logic       cmp_bit;

    modport source (output valid, output mode, output restart, output presence,
                    output id_bit, output cmp_bit, input ready);
    modport sink   (input valid, input mode, input restart, input presence,
                    input id_bit, input cmp_bit, output ready);
endinterface

>>> hw/rtl/ows_rsp_if.sv
// Output channel of the ROM search engine: one action/result word per handshake.
// Standalone; fields follow the engine's result word.
interface ows_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  out_byte;
    logic        direction;
    logic        found;
    logic [63:0] rom_id;
    logic        last_device;
    logic [6:0]  last_discrepancy;
    logic [3:0]  family_discrepancy;
    logic        last_of_run;

    modport source (output valid, output action, output out_byte, output direction,
                    output found, output rom_id, output last_device,
                    output last_discrepancy, output family_discrepancy,
                    output last_of_run, input ready);
    modport sink   (input valid, input action, input out_byte, input direction,
                    input found, input rom_id, input last_device,
                    input last_discrepancy, input family_discrepancy,
                    input last_of_run, output ready);
endinterface

>>> hw/rtl/onewire_rom_search_engine.sv
// 1-Wire ROM search sequencer: search state update and a small result queue.
// Result words are written into the queue when their input word is taken, and offered from it.
// Throughput: one input word per cycle; the 64th bit pair queues two words
// (direction write, then finish), drained one per cycle while rsp.ready is high from a 4-entry queue.
// Input ready drops while fewer than two queue slots are free.
// Reset (rst_n low, asynchronous) clears all search state; no clearing pass.
module onewire_rom_search_engine
    import ows_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    ows_cmd_if.sink    cmd,
    ows_rsp_if.source  rsp
);

    logic [7:0]  search_cmd_reg;
    logic [63:0] rom_reg,    rom_next;
    logic [6:0]  disc_reg,   disc_next;
    logic [3:0]  fam_reg,    fam_next;
    logic        done_reg,   done_next;
    logic [6:0]  bitpos_reg, bitpos_next;
    logic [6:0]  zb_reg,     zb_next;
    logic [7:0]  crc_reg,    crc_next;
    logic [1:0]  phase_reg,  phase_next;

    ows_result_t fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    logic        accept;
    logic        pop;
    logic [1:0]  push_n;
    ows_result_t res_first, res_second;

    logic        do_finish;
    logic        dir_emitted;
    logic        ok;
    logic        dir;
    logic [6:0]  pos;
    logic [5:0]  sh;
    logic [2:0]  byte_idx;
    logic        finish_found;

    assign cmd.ready = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign accept    = cmd.valid && cmd.ready;
    assign pop       = rsp.valid && rsp.ready;

    always_comb
    begin
        rom_next     = rom_reg;
        disc_next    = disc_reg;
        fam_next     = fam_reg;
        done_next    = done_reg;
        bitpos_next  = bitpos_reg;
        zb_next      = zb_reg;
        crc_next     = crc_reg;
        phase_next   = phase_reg;
        do_finish    = 1'b0;
        dir_emitted  = 1'b0;
        ok           = 1'b0;
        dir          = 1'b0;
        pos          = bitpos_reg;
        sh           = 6'(bitpos_reg - 7'd1);
        byte_idx     = 3'(pos[5:3] - 3'd1);
        finish_found = 1'b0;
        res_first    = '0;
        res_second   = '0;
        push_n       = 2'd0;

        if (accept)
        begin
            case (cmd.mode)
                MODE_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        if (cmd.restart)
                        begin
                            disc_next = '0;
                            fam_next  = '0;
                            done_next = 1'b0;
                        end
                        bitpos_next = 7'd1;
                        zb_next     = '0;
                        crc_next    = '0;
                        if (done_next)
                        begin
                            do_finish = 1'b1;
                        end
                        else
                        begin
                            phase_next       = PH_WAIT;
                            res_first.action = ACT_RESET;
                            push_n           = 2'd1;
                        end
                    end
                end
                MODE_RESET:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (cmd.presence != PRES_OK)
                        begin
                            disc_next        = '0;
                            fam_next         = '0;
                            done_next        = 1'b0;
                            phase_next       = PH_IDLE;
                            res_first.action = ACT_FINISH;
                        end
                        else
                        begin
                            phase_next         = PH_READ;
                            res_first.action   = ACT_CMD;
                            res_first.out_byte = search_cmd_reg;
                        end
                        push_n = 2'd1;
                    end
                end
                MODE_BITS:
                begin
                    if (phase_reg == PH_READ)
                    begin
                        if (cmd.id_bit && cmd.cmp_bit)
                        begin
                            do_finish = 1'b1;
                        end
                        else
                        begin
                            if (cmd.id_bit != cmd.cmp_bit)
                            begin
                                dir = cmd.id_bit;
                            end
                            else
                            begin
                                // both zero: follow earlier path, take 1 at the last
                                // discrepancy, else the zero branch
                                if (pos < disc_reg)
                                begin
                                    dir = rom_reg[sh];
                                end
                                else
                                begin
                                    dir = (pos == disc_reg);
                                end
                                if (!dir)
                                begin
                                    zb_next = pos;
                                    if (pos < FAMILY_BIT_END)
                                    begin
                                        fam_next = 4'(pos);
                                    end
                                end
                            end
                            rom_next[sh] = dir;
                            if (pos[2:0] == 3'd0)
                            begin
                                crc_next = crc8_byte(crc_reg, rom_next[byte_idx*8 +: 8]);
                            end
                            bitpos_next = 7'(pos + 7'd1);
                            dir_emitted = 1'b1;
                            res_first.action    = ACT_DIR;
                            res_first.direction = dir;
                            push_n = 2'd1;
                            if (bitpos_next >= ROM_BITS_END)
                            begin
                                do_finish = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // snapshot for the first word before any finish update
        res_first.rom_id             = rom_next;
        res_first.last_device        = done_next;
        res_first.last_discrepancy   = disc_next;
        res_first.family_discrepancy = fam_next;
        res_first.last_of_run        = !do_finish;

        if (do_finish)
        begin
            ok = (bitpos_next >= ROM_BITS_END) && (crc_next == 8'd0);
            if (ok)
            begin
                disc_next = zb_next;
                if (zb_next == 7'd0)
                begin
                    done_next = 1'b1;
                end
            end
            finish_found = ok;
            if (!ok || (rom_next[7:0] == 8'd0))
            begin
                disc_next    = '0;
                fam_next     = '0;
                done_next    = 1'b0;
                finish_found = 1'b0;
            end
            phase_next = PH_IDLE;
        end

        res_second.action             = ACT_FINISH;
        res_second.out_byte           = '0;
        res_second.direction          = 1'b0;
        res_second.found              = finish_found;
        res_second.rom_id             = rom_next;
        res_second.last_device        = done_next;
        res_second.last_discrepancy   = disc_next;
        res_second.family_discrepancy = fam_next;
        res_second.last_of_run        = 1'b1;

        if (do_finish)
        begin
            if (dir_emitted)
            begin
                push_n = 2'd2;
            end
            else
            begin
                res_first = res_second;
                push_n    = 2'd1;
            end
        end

        count_next = count_reg + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_cmd_reg <= SEARCH_CMD_RESET;
            rom_reg        <= '0;
            disc_reg       <= '0;
            fam_reg        <= '0;
            done_reg       <= 1'b0;
            bitpos_reg     <= 7'd1;
            zb_reg         <= '0;
            crc_reg        <= '0;
            phase_reg      <= PH_IDLE;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                search_cmd_reg <= cfg_wdata;
            end
            rom_reg    <= rom_next;
            disc_reg   <= disc_next;
            fam_reg    <= fam_next;
            done_reg   <= done_next;
            bitpos_reg <= bitpos_next;
            zb_reg     <= zb_next;
            crc_reg    <= crc_next;
            phase_reg  <= phase_next;
            wr_ptr_reg <= FIFO_AW'(wr_ptr_reg + FIFO_AW'(push_n));
            if (pop)
            begin
                rd_ptr_reg <= FIFO_AW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

    // result queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res_first;
        end
        if (push_n == 2'd2)
        begin
            fifo_mem[FIFO_AW'(wr_ptr_reg + 1'b1)] <= res_second;
        end
    end

    assign rsp.valid              = (count_reg != '0);
    assign rsp.action             = fifo_mem[rd_ptr_reg].action;
    assign rsp.out_byte           = fifo_mem[rd_ptr_reg].out_byte;
    assign rsp.direction          = fifo_mem[rd_ptr_reg].direction;
    assign rsp.found              = fifo_mem[rd_ptr_reg].found;
    assign rsp.rom_id             = fifo_mem[rd_ptr_reg].rom_id;
    assign rsp.last_device        = fifo_mem[rd_ptr_reg].last_device;
    assign rsp.last_discrepancy   = fifo_mem[rd_ptr_reg].last_discrepancy;
    assign rsp.family_discrepancy = fifo_mem[rd_ptr_reg].family_discrepancy;
    assign rsp.last_of_run        = fifo_mem[rd_ptr_reg].last_of_run;

endmodule

>>> tb/tb_onewire_rom_search_engine.sv
`timescale 1ns / 100ps
// Self-checking testbench for onewire_rom_search_engine: a scoreboard class predicts
// every result word, and plain tasks drive simulated device populations through the search.
// Depends on ows_pkg, ows_cmd_if, ows_rsp_if and the engine RTL.
module tb_onewire_rom_search_engine
    import ows_pkg::*;
;

    localparam logic [1:0] MODE_NONE   = 2'd3;
    localparam logic [1:0] PRES_SHORT  = 2'd1;
    localparam logic [1:0] PRES_ABSENT = 2'd2;
    localparam logic [1:0] PRES_BAD    = 2'd3;

    class rom_search_scoreboard;
        ows_result_t expected_q[$];
        logic [7:0]  command_byte;
        logic [63:0] rom_bits;
        logic [6:0]  last_disc;
        logic [3:0]  family_disc;
        logic        last_dev;
        logic [6:0]  bit_pos;
        logic [6:0]  zero_branch;
        logic [7:0]  crc_acc;
        logic [1:0]  phase;
        logic        chosen_dir;
        int          errors;

        function new();
            errors       = 0;
            command_byte = SEARCH_CMD_RESET;
            rom_bits     = '0;
            last_disc    = '0;
            family_disc  = '0;
            last_dev     = 1'b0;
            bit_pos      = 7'd1;
            zero_branch  = '0;
            crc_acc      = '0;
            phase        = PH_IDLE;
            chosen_dir   = 1'b0;
        endfunction

        // reflected CRC-8, data taken LSB first
        static function logic [7:0] crc_update(logic [7:0] crc, logic [7:0] data);
            logic fb;
            for (int i = 0; i < 8; i++)
            begin
                fb  = crc[0] ^ data[i];
                crc = {1'b0, crc[7:1]} ^ (fb ? CRC_POLY : 8'h00);
            end
            return crc;
        endfunction

        function ows_result_t make_word(logic [1:0] act, logic [7:0] b, logic d, logic f);
            ows_result_t w;
            w.action             = act;
            w.out_byte           = b;
            w.direction          = d;
            w.found              = f;
            w.rom_id             = rom_bits;
            w.last_device        = last_dev;
            w.last_discrepancy   = last_disc;
            w.family_discrepancy = family_disc;
            w.last_of_run        = 1'b0;
            return w;
        endfunction

        function ows_result_t finish_word();
            logic ok;
            ok = (bit_pos >= ROM_BITS_END) && (crc_acc == 8'h00);
            if (ok)
            begin
                last_disc = zero_branch;
                if (last_disc == 7'd0)
                    last_dev = 1'b1;
            end
            // a zero family byte never counts as a device
            if (!ok || rom_bits[7:0] == 8'h00)
            begin
                last_disc   = '0;
                family_disc = '0;
                last_dev    = 1'b0;
                ok          = 1'b0;
            end
            phase = PH_IDLE;
            return make_word(ACT_FINISH, 8'h00, 1'b0, ok);
        endfunction

        // Notes one accepted input word; returns the number of result words it causes.
        function int note_input(logic [1:0] mode, logic restart, logic [1:0] presence,
                                logic id_bit, logic cmp_bit);
            ows_result_t words[2];
            int          n;
            int          sh;
            logic [6:0]  pos;
            logic        d;
            n = 0;
            if (mode == MODE_START && phase == PH_IDLE)
            begin
                if (restart)
                begin
                    last_disc   = '0;
                    family_disc = '0;
                    last_dev    = 1'b0;
                end
                bit_pos     = 7'd1;
                zero_branch = '0;
                crc_acc     = '0;
                if (last_dev)
                begin
                    words[n] = finish_word();
                    n++;
                end
                else
                begin
                    phase    = PH_WAIT;
                    words[n] = make_word(ACT_RESET, 8'h00, 1'b0, 1'b0);
                    n++;
                end
            end
            else if (mode == MODE_RESET && phase == PH_WAIT)
            begin
                if (presence != PRES_OK)
                begin
                    last_disc   = '0;
                    family_disc = '0;
                    last_dev    = 1'b0;
                    phase       = PH_IDLE;
                    words[n]    = make_word(ACT_FINISH, 8'h00, 1'b0, 1'b0);
                end
                else
                begin
                    phase    = PH_READ;
                    words[n] = make_word(ACT_CMD, command_byte, 1'b0, 1'b0);
                end
                n++;
            end
            else if (mode == MODE_BITS && phase == PH_READ)
            begin
                if (id_bit && cmp_bit)
                begin
                    words[n] = finish_word();
                    n++;
                end
                else
                begin
                    pos = bit_pos;
                    sh  = int'(pos) - 1;
                    if (id_bit != cmp_bit)
                        d = id_bit;
                    else
                    begin
                        // conflict: follow the old path below the discrepancy, take 1 at it
                        if (pos < last_disc)
                            d = rom_bits[sh];
                        else
                            d = (pos == last_disc);
                        if (!d)
                        begin
                            zero_branch = pos;
                            if (pos < FAMILY_BIT_END)
                                family_disc = pos[3:0];
                        end
                    end
                    rom_bits[sh] = d;
                    chosen_dir   = d;
                    words[n]     = make_word(ACT_DIR, 8'h00, d, 1'b0);
                    n++;
                    if (pos[2:0] == 3'd0)
                        crc_acc = crc_update(crc_acc, rom_bits[(int'(pos) / 8 - 1) * 8 +: 8]);
                    bit_pos = pos + 7'd1;
                    if (bit_pos >= ROM_BITS_END)
                    begin
                        words[n] = finish_word();
                        n++;
                    end
                end
            end
            if (n > 0)
                words[n - 1].last_of_run = 1'b1;
            for (int k = 0; k < n; k++)
                expected_q.push_back(words[k]);
            return n;
        endfunction

        function void check_result(ows_result_t got);
            ows_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word: action %0d rom_id %h", got.action, got.rom_id);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.action != want.action)
            begin
                $error("action: expected %0d, got %0d", want.action, got.action);
                errors++;
            end
            if (got.out_byte != want.out_byte)
            begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.direction != want.direction)
            begin
                $error("direction: expected %0d, got %0d", want.direction, got.direction);
                errors++;
            end
            if (got.found != want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.rom_id != want.rom_id)
            begin
                $error("rom_id: expected %h, got %h", want.rom_id, got.rom_id);
                errors++;
            end
            if (got.last_device != want.last_device)
            begin
                $error("last_device: expected %0d, got %0d", want.last_device, got.last_device);
                errors++;
            end
            if (got.last_discrepancy != want.last_discrepancy)
            begin
                $error("last_discrepancy: expected %0d, got %0d",
                       want.last_discrepancy, got.last_discrepancy);
                errors++;
            end
            if (got.family_discrepancy != want.family_discrepancy)
            begin
                $error("family_discrepancy: expected %0d, got %0d",
                       want.family_discrepancy, got.family_discrepancy);
                errors++;
            end
            if (got.last_of_run != want.last_of_run)
            begin
                $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic [63:0] devices[$];
    int          useful_items = 0;
    int          phase_end    = 0;
    int          hold_left    = 0;
    bit          quiet        = 1'b0;

    rom_search_scoreboard search_sb = new();

    ows_cmd_if cmd_ch();
    ows_rsp_if rsp_ch();

    onewire_rom_search_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls per word, plus a long hold-off on request
    initial
    begin
        int          stall;
        ows_result_t got;
        stall        = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.action             = rsp_ch.action;
                got.out_byte           = rsp_ch.out_byte;
                got.direction          = rsp_ch.direction;
                got.found              = rsp_ch.found;
                got.rom_id             = rsp_ch.rom_id;
                got.last_device        = rsp_ch.last_device;
                got.last_discrepancy   = rsp_ch.last_discrepancy;
                got.family_discrepancy = rsp_ch.family_discrepancy;
                got.last_of_run        = rsp_ch.last_of_run;
                search_sb.check_result(got);
                stall = quiet ? 0 : $urandom_range(0, 8);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [1:0] mode, input logic restart,
                             input logic [1:0] presence, input logic id_bit,
                             input logic cmp_bit);
        int gap;
        int n;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= mode;
        cmd_ch.restart  <= restart;
        cmd_ch.presence <= presence;
        cmd_ch.id_bit   <= id_bit;
        cmd_ch.cmp_bit  <= cmp_bit;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        n = search_sb.note_input(mode, restart, presence, id_bit, cmp_bit);
        if (n > 0)
            useful_items++;
    endtask

    // wait for every expected word, then wait out ignored words still in flight
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (search_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_command(input logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        search_sb.command_byte = value;
    endtask

    // force the engine back to idle so that a fresh start is taken
    task automatic settle_idle();
        if (search_sb.phase == PH_WAIT)
            send_word(MODE_RESET, 1'b0, PRES_SHORT, 1'b0, 1'b0);
        else if (search_sb.phase == PH_READ)
            send_word(MODE_BITS, 1'b0, PRES_OK, 1'b1, 1'b1);
    endtask

    // Devices share a random prefix so that branches fall at varied positions;
    // a few have a zero family byte or a broken CRC.
    task automatic make_population();
        logic [63:0] base;
        logic [63:0] dev;
        logic [7:0]  crc;
        int          count;
        int          keep;
        int          variant;
        devices.delete();
        count = $urandom_range(1, 6);
        base  = {$urandom, $urandom};
        for (int k = 0; k < count; k++)
        begin
            dev  = base;
            keep = $urandom_range(0, 56);
            for (int b = keep; b < 64; b++)
                dev[b] = 1'($urandom_range(0, 1));
            variant = $urandom_range(0, 9);
            if (variant == 0)
                dev[7:0] = 8'h00;
            crc = 8'h00;
            for (int j = 0; j < 7; j++)
                crc = rom_search_scoreboard::crc_update(crc, dev[j * 8 +: 8]);
            if (variant != 1)
                dev[63:56] = crc;
            devices.push_back(dev);
        end
    endtask

    // full enumeration of a population, answering each slot pair as the bus would
    task automatic search_run();
        logic [7:0] live;
        logic       id_b;
        logic       cmp_b;
        make_population();
        settle_idle();
        for (int s = 0; s < devices.size() + 2; s++)
        begin
            if (useful_items >= phase_end)
                break;
            send_word(MODE_START, s == 0, 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (search_sb.phase == PH_IDLE)
                break;
            send_word(MODE_RESET, 1'($urandom_range(0, 1)), PRES_OK,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            live = '1;
            for (int p = 0; p < 64 && search_sb.phase == PH_READ; p++)
            begin
                id_b  = 1'b1;
                cmp_b = 1'b1;
                for (int k = 0; k < devices.size(); k++)
                begin
                    if (live[k])
                    begin
                        id_b  = id_b & devices[k][p];
                        cmp_b = cmp_b & ~devices[k][p];
                    end
                end
                send_word(MODE_BITS, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          id_b, cmp_b);
                for (int k = 0; k < devices.size(); k++)
                    if (devices[k][p] != search_sb.chosen_dir)
                        live[k] = 1'b0;
            end
        end
    endtask

    task automatic broken_run();
        settle_idle();
        send_word(MODE_START, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (search_sb.phase == PH_WAIT)
            send_word(MODE_RESET, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 12))
            send_word(MODE_BITS, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_phase(input int target);
        int first;
        int pick;
        first     = useful_items;
        phase_end = first + target;
        while (useful_items - first < target)
        begin
            if ($urandom_range(0, 4) == 0)
                quiet = !quiet;
            pick = $urandom_range(0, 99);
            if (pick < 75)
                search_run();
            else if (pick < 90)
                broken_run();
            else
                repeat ($urandom_range(1, 4))
                    send_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 8'h00;
        cmd_ch.valid    = 1'b0;
        cmd_ch.mode     = MODE_START;
        cmd_ch.restart  = 1'b0;
        cmd_ch.presence = PRES_OK;
        cmd_ch.id_bit   = 1'b0;
        cmd_ch.cmp_bit  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // words out of phase, every presence code, each bit pair, early finish
        send_word(MODE_NONE,  1'b1, PRES_BAD,    1'b1, 1'b1);
        send_word(MODE_RESET, 1'b0, PRES_OK,     1'b0, 1'b0);
        send_word(MODE_BITS,  1'b0, PRES_OK,     1'b1, 1'b1);
        send_word(MODE_START, 1'b1, PRES_OK,     1'b0, 1'b0);
        send_word(MODE_START, 1'b0, PRES_OK,     1'b0, 1'b0);
        send_word(MODE_BITS,  1'b0, PRES_OK,     1'b0, 1'b1);
        send_word(MODE_NONE,  1'b0, PRES_OK,     1'b0, 1'b0);
        send_word(MODE_RESET, 1'b0, PRES_SHORT,  1'b0, 1'b0);
        send_word(MODE_START, 1'b0, PRES_OK,     1'b0, 1'b0);
        send_word(MODE_RESET, 1'b1, PRES_ABSENT, 1'b1, 1'b0);
        send_word(MODE_START, 1'b1, PRES_OK,     1'b0, 1'b0);
        send_word(MODE_RESET, 1'b0, PRES_BAD,    1'b0, 1'b1);
        send_word(MODE_START, 1'b1, PRES_OK,     1'b0, 1'b0);
        send_word(MODE_RESET, 1'b0, PRES_OK,     1'b0, 1'b0);
        send_word(MODE_RESET, 1'b0, PRES_OK,     1'b0, 1'b0);
        send_word(MODE_START, 1'b1, PRES_OK,     1'b0, 1'b0);
        send_word(MODE_BITS,  1'b0, PRES_OK,     1'b0, 1'b1);
        send_word(MODE_BITS,  1'b1, PRES_BAD,    1'b1, 1'b0);
        send_word(MODE_BITS,  1'b0, PRES_OK,     1'b0, 1'b0);
        send_word(MODE_BITS,  1'b0, PRES_OK,     1'b1, 1'b1);

        write_command(8'hEC);
        hold_left = 400;
        random_phase(260);
        write_command(8'h00);
        random_phase(130);
        drain();
        random_phase(130);
        write_command(8'hFF);
        random_phase(260);
        write_command(8'($urandom_range(0, 255)));
        random_phase(260);
        write_command(SEARCH_CMD_RESET);
        random_phase(130);
        drain();
        repeat (10) @(posedge clk);

        if (search_sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
